[rtl/ffha_pkg.sv]
// Shared codes, constants and controller/datapath interface types of the heap allocator.
`default_nettype none
package ffha_pkg;

  localparam logic [1:0] ACT_INIT    = 2'd0;
  localparam logic [1:0] ACT_ALLOC   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FIT    = 3'd1;
  localparam logic [2:0] ST_NO_NODE   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_ZERO      = 3'd4;

  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HEAP_BASE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HEAP_SIZE = 1'b1;

  localparam logic [31:0] HEAP_BASE_RST = 32'd0;
  localparam logic [31:0] HEAP_SIZE_RST = 32'd65536;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 72;

  typedef struct packed {
    logic       init;
    logic       capture;
    logic       walk_used;
    logic       rd;
    logic       advance;
    logic       alloc_w1;
    logic       alloc_w2;
    logic       rel_w1;
    logic       rel_w2;
    logic       set_status;
    logic [2:0] status;
    logic       load_out;
  } ffha_cmd_t;

  typedef struct packed {
    logic walk_end;
    logic fit;
    logic match;
    logic spare_ok;
    logic zero_req;
    logic out_busy;
  } ffha_sts_t;

endpackage
`default_nettype wire

[rtl/ffha_ctrl.sv]
// Controller state machine of the heap allocator.
`default_nettype none
module ffha_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  input  wire [1:0]             in_action,
  output logic                  in_tready,
  input  ffha_pkg::ffha_sts_t   sts,
  output ffha_pkg::ffha_cmd_t   cmd
);

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_RD   = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_W1   = 7'b0010000,
    S_W2   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   alloc_r, alloc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      alloc_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      alloc_r <= alloc_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    alloc_nxt = alloc_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture   = 1'b1;
          cmd.walk_used = (in_action == ffha_pkg::ACT_RELEASE);
          unique case (in_action)
            ffha_pkg::ACT_INIT: begin
              cmd.init  = 1'b1;
              state_nxt = S_OUT;
            end
            ffha_pkg::ACT_ALLOC: begin
              alloc_nxt = 1'b1;
              state_nxt = S_RD;
            end
            ffha_pkg::ACT_RELEASE: begin
              alloc_nxt = 1'b0;
              state_nxt = S_RD;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_RD: begin
        priority if (alloc_r && sts.zero_req) begin
          cmd.set_status = 1'b1;
          cmd.status     = ffha_pkg::ST_ZERO;
          state_nxt      = S_OUT;
        end else if (sts.walk_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = alloc_r ? ffha_pkg::ST_NO_FIT : ffha_pkg::ST_NOT_FOUND;
          state_nxt      = S_OUT;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        priority if (alloc_r && sts.fit && !sts.spare_ok) begin
          cmd.set_status = 1'b1;
          cmd.status     = ffha_pkg::ST_NO_NODE;
          state_nxt      = S_OUT;
        end else if ((alloc_r && sts.fit) || (!alloc_r && sts.match)) begin
          state_nxt = S_W1;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_W1: begin
        cmd.alloc_w1 = alloc_r;
        cmd.rel_w1   = !alloc_r;
        state_nxt    = S_W2;
      end
      S_W2: begin
        cmd.alloc_w2 = alloc_r;
        cmd.rel_w2   = !alloc_r;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule
`default_nettype wire

[rtl/ffha_dp.sv]
// Datapath of the heap allocator: node memories, list heads, walk registers and result register.
`default_nettype none
module ffha_dp #(
  parameter int unsigned NODE_COUNT    = 16,
  parameter int unsigned ADDRESS_WIDTH = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire [ffha_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire [31:0]                           cfg_wdata,
  input  wire [31:0]                           in_req,
  input  wire [31:0]                           in_rel,
  input  ffha_pkg::ffha_cmd_t                  cmd,
  output ffha_pkg::ffha_sts_t                  sts,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [31:0]                          out_block_address,
  output logic [2:0]                           out_status,
  output logic [31:0]                          out_free_bytes
);

  localparam int unsigned IW  = $clog2(NODE_COUNT + 1);
  localparam int unsigned AIW = $clog2(NODE_COUNT);
  localparam logic [IW-1:0] NIL = IW'(NODE_COUNT);

  logic [ADDRESS_WIDTH-1:0] mem_start [NODE_COUNT];
  logic [31:0]              mem_len   [NODE_COUNT];
  logic [IW-1:0]            mem_link  [NODE_COUNT];

  logic [31:0]              heap_base_r, heap_size_r;
  logic [31:0]              req_r;
  logic [ADDRESS_WIDTH-1:0] where_r;
  logic [IW-1:0]            cur_r, prev_r, free_head_r, used_head_r;
  logic [IW-1:0]            steps_r;
  logic [31:0]              free_total_r;
  logic [NODE_COUNT-1:0]    valid_r;
  logic [ADDRESS_WIDTH-1:0] rd_start_r;
  logic [31:0]              rd_len_r;
  logic [IW-1:0]            rd_link_r;
  logic                     rd_valid_r;
  logic [ADDRESS_WIDTH-1:0] addr_r;
  logic [2:0]               status_r;
  logic                     out_valid_r;
  logic [31:0]              out_addr_r, out_free_r;
  logic [2:0]               out_status_r;

  logic [ADDRESS_WIDTH-1:0] e_start;
  logic [31:0]              e_len, new_len;
  logic [IW-1:0]            e_link;
  logic [AIW-1:0]           spare_idx, cur_idx, prev_idx;
  logic                     spare_ok;

  logic                     start_we, len_we, link_we;
  logic [AIW-1:0]           start_wa, len_wa, link_wa;
  logic [ADDRESS_WIDTH-1:0] start_wd;
  logic [31:0]              len_wd;
  logic [IW-1:0]            link_wd;

  assign cur_idx  = cur_r[AIW-1:0];
  assign prev_idx = prev_r[AIW-1:0];
  assign e_start  = rd_valid_r ? rd_start_r : '0;
  assign e_len    = rd_valid_r ? rd_len_r : '0;
  assign e_link   = rd_valid_r ? rd_link_r : NIL;
  assign new_len  = e_len - req_r;

  always_comb begin
    spare_ok  = 1'b0;
    spare_idx = '0;
    for (int i = NODE_COUNT - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        spare_ok  = 1'b1;
        spare_idx = AIW'(i);
      end
    end
  end

  assign sts.walk_end = (cur_r == NIL) || (steps_r == IW'(NODE_COUNT));
  assign sts.fit      = (e_len >= req_r);
  assign sts.match    = (e_start == where_r);
  assign sts.spare_ok = spare_ok;
  assign sts.zero_req = (req_r == 32'd0);
  assign sts.out_busy = out_valid_r && !out_tready;

  always_comb begin
    start_we = 1'b0;
    start_wa = '0;
    start_wd = '0;
    len_we   = 1'b0;
    len_wa   = '0;
    len_wd   = '0;
    link_we  = 1'b0;
    link_wa  = '0;
    link_wd  = NIL;
    priority if (cmd.init) begin
      start_we = 1'b1;
      start_wd = ADDRESS_WIDTH'(heap_base_r);
      len_we   = 1'b1;
      len_wd   = heap_size_r;
      link_we  = 1'b1;
    end else if (cmd.alloc_w1) begin
      start_we = 1'b1;
      start_wa = spare_idx;
      start_wd = e_start;
      len_we   = 1'b1;
      len_wa   = spare_idx;
      len_wd   = req_r;
      link_we  = 1'b1;
      link_wa  = spare_idx;
      link_wd  = used_head_r;
    end else if (cmd.alloc_w2) begin
      if (new_len != 32'd0) begin
        start_we = 1'b1;
        start_wa = cur_idx;
        start_wd = e_start + ADDRESS_WIDTH'(req_r);
        len_we   = 1'b1;
        len_wa   = cur_idx;
        len_wd   = new_len;
      end else if (prev_r != NIL) begin
        link_we = 1'b1;
        link_wa = prev_idx;
        link_wd = e_link;
      end
    end else if (cmd.rel_w1) begin
      if (prev_r != NIL) begin
        link_we = 1'b1;
        link_wa = prev_idx;
        link_wd = e_link;
      end
    end else if (cmd.rel_w2) begin
      link_we = 1'b1;
      link_wa = cur_idx;
      link_wd = free_head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start_we) begin
      mem_start[start_wa] <= start_wd;
    end
    if (cmd.rd) begin
      rd_start_r <= mem_start[cur_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      mem_len[len_wa] <= len_wd;
    end
    if (cmd.rd) begin
      rd_len_r <= mem_len[cur_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      mem_link[link_wa] <= link_wd;
    end
    if (cmd.rd) begin
      rd_link_r <= mem_link[cur_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= ffha_pkg::HEAP_BASE_RST;
      heap_size_r <= ffha_pkg::HEAP_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ffha_pkg::CFG_HEAP_BASE: heap_base_r <= cfg_wdata;
        ffha_pkg::CFG_HEAP_SIZE: heap_size_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      free_head_r  <= NIL;
      used_head_r  <= NIL;
      free_total_r <= '0;
      cur_r        <= NIL;
      prev_r       <= NIL;
      steps_r      <= '0;
      status_r     <= ffha_pkg::ST_OK;
      rd_valid_r   <= 1'b0;
    end else begin
      if (cmd.capture) begin
        cur_r    <= cmd.walk_used ? used_head_r : free_head_r;
        prev_r   <= NIL;
        steps_r  <= '0;
        status_r <= ffha_pkg::ST_OK;
      end
      if (cmd.set_status) begin
        status_r <= cmd.status;
      end
      if (cmd.rd) begin
        rd_valid_r <= valid_r[cur_idx];
      end
      if (cmd.advance) begin
        prev_r  <= cur_r;
        cur_r   <= e_link;
        steps_r <= steps_r + 1'b1;
      end
      if (cmd.init) begin
        valid_r      <= {{(NODE_COUNT-1){1'b0}}, (heap_size_r != 32'd0)};
        free_head_r  <= (heap_size_r != 32'd0) ? '0 : NIL;
        used_head_r  <= NIL;
        free_total_r <= heap_size_r;
      end
      if (cmd.alloc_w1) begin
        valid_r[spare_idx] <= 1'b1;
        used_head_r        <= IW'(spare_idx);
        free_total_r       <= free_total_r - req_r;
      end
      if (cmd.alloc_w2 && (new_len == 32'd0)) begin
        valid_r[cur_idx] <= 1'b0;
        if (prev_r == NIL) begin
          free_head_r <= e_link;
        end
      end
      if (cmd.rel_w1 && (prev_r == NIL)) begin
        used_head_r <= e_link;
      end
      if (cmd.rel_w2) begin
        free_head_r  <= cur_r;
        free_total_r <= free_total_r + e_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_req;
      where_r <= ADDRESS_WIDTH'(in_rel);
      addr_r  <= '0;
    end else if (cmd.alloc_w1) begin
      addr_r <= e_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_addr_r   <= 32'(addr_r);
      out_status_r <= status_r;
      out_free_r   <= free_total_r;
    end
  end

  assign out_tvalid        = out_valid_r;
  assign out_block_address = out_addr_r;
  assign out_status        = out_status_r;
  assign out_free_bytes    = out_free_r;

endmodule
`default_nettype wire

[rtl/first_fit_heap_allocator.sv]
// Top level of the first-fit heap allocator over a fixed pool of range nodes.
// From acceptance, init and the unused action go straight to the result; a zero-size request
// ends in the first read state; else the walk visits at most NODE_COUNT list nodes, reading
// one node at a time from the node memories, and a hit adds the write states W1 and W2.
// One item is in work at a time; the next is taken the cycle after the result is loaded.
// After reset the block builds the initial heap in its init state, with in_tready low.
`default_nettype none
module first_fit_heap_allocator #(
  parameter int unsigned NODE_COUNT    = 16,
  parameter int unsigned ADDRESS_WIDTH = 32
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire [ffha_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  wire [31:0]                            cfg_wdata,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  // action [1:0], request_size [33:2], release_address [65:34], zero padding above.
  input  wire [ffha_pkg::IN_TDATA_W-1:0]        in_tdata,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  // block_address [31:0], status [34:32], free_bytes [66:35], zero padding above.
  output logic [ffha_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  ffha_pkg::ffha_cmd_t cmd;
  ffha_pkg::ffha_sts_t sts;
  logic [31:0]         blk_addr, free_bytes;
  logic [2:0]          status;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tdata[1:0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffha_dp #(
    .NODE_COUNT    (NODE_COUNT),
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_req            (in_tdata[33:2]),
    .in_rel            (in_tdata[65:34]),
    .cmd               (cmd),
    .sts               (sts),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_block_address (blk_addr),
    .out_status        (status),
    .out_free_bytes    (free_bytes)
  );

  assign out_tdata = {5'd0, free_bytes, status, blk_addr};

endmodule
`default_nettype wire

[rtl/ffha_checker.sv]
// Port-level checks of the heap allocator and their attachment to the top level.
`default_nettype none
module ffha_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_tvalid,
  input wire                               in_tready,
  input wire                               out_tvalid,
  input wire                               out_tready,
  input wire [ffha_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

[test/first_fit_heap_allocator_test.sv]
// Testbench for the first-fit heap allocator: directed and random items checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module first_fit_heap_allocator_test;

  localparam int NODES = 16;
  localparam logic [4:0] NIL = 5'd16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] addr;
    logic [2:0]  status;
    logic [31:0] free_bytes;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ffha_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ffha_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ffha_pkg::OUT_TDATA_W-1:0] out_tdata;

  first_fit_heap_allocator i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  logic [31:0] base_reg, size_reg;
  logic [31:0] rng_start [NODES];
  logic [31:0] rng_len [NODES];
  logic [4:0]  rng_link [NODES];
  logic [4:0]  free_head, used_head;
  logic [31:0] free_sum;

  heap_result_t pending_results[$];
  logic [31:0] live_blocks[$];
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int results_seen = 0;
  bit rx_stall_on = 1'b1;
  bit tx_gap_on = 1'b1;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic heap_init_model();
    for (int i = 0; i < NODES; i++) begin
      rng_start[i] = '0;
      rng_len[i] = '0;
      rng_link[i] = NIL;
    end
    used_head = NIL;
    free_sum = size_reg;
    if (size_reg == 0) begin
      free_head = NIL;
    end else begin
      rng_start[0] = base_reg;
      rng_len[0] = size_reg;
      free_head = 5'd0;
    end
  endtask

  function automatic logic [4:0] spare_node();
    for (int i = 0; i < NODES; i++) if (rng_len[i] == 0) return i[4:0];
    return NIL;
  endfunction

  task automatic predict_alloc(input logic [31:0] req, output heap_result_t r);
    logic [4:0] prev, cur, nn;
    prev = NIL;
    cur = free_head;
    r.addr = '0;
    r.status = ffha_pkg::ST_NO_FIT;
    if (req == 0) begin
      r.status = ffha_pkg::ST_ZERO;
      return;
    end
    for (int s = 0; s < NODES && cur < NIL; s++) begin
      if (rng_len[cur] >= req) begin
        nn = spare_node();
        if (nn >= NIL) begin
          r.status = ffha_pkg::ST_NO_NODE;
          return;
        end
        rng_start[nn] = rng_start[cur];
        rng_len[nn] = req;
        rng_start[cur] = rng_start[cur] + req;
        rng_len[cur] = rng_len[cur] - req;
        free_sum = free_sum - req;
        if (rng_len[cur] == 0) begin
          if (prev >= NIL) free_head = rng_link[cur];
          else rng_link[prev] = rng_link[cur];
          rng_start[cur] = '0;
          rng_link[cur] = NIL;
        end
        rng_link[nn] = used_head;
        used_head = nn;
        r.addr = rng_start[nn];
        r.status = ffha_pkg::ST_OK;
        live_blocks.push_back(r.addr);
        return;
      end
      prev = cur;
      cur = rng_link[cur];
    end
  endtask

  task automatic predict_release(input logic [31:0] where, output logic [2:0] st);
    logic [4:0] prev, cur;
    prev = NIL;
    cur = used_head;
    st = ffha_pkg::ST_NOT_FOUND;
    for (int s = 0; s < NODES && cur < NIL; s++) begin
      if (rng_start[cur] == where) begin
        if (prev >= NIL) used_head = rng_link[cur];
        else rng_link[prev] = rng_link[cur];
        rng_link[cur] = free_head;
        free_head = cur;
        free_sum = free_sum + rng_len[cur];
        st = ffha_pkg::ST_OK;
        return;
      end
      prev = cur;
      cur = rng_link[cur];
    end
  endtask

  task automatic send_item(input logic [1:0] act, input logic [31:0] req,
                           input logic [31:0] rel);
    heap_result_t r;
    if (tx_gap_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) @(posedge clk);
    in_tdata <= {6'd0, rel, req, act};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
    r = '0;
    r.status = ffha_pkg::ST_OK;
    case (act)
      ffha_pkg::ACT_INIT: begin
        heap_init_model();
        live_blocks.delete();
      end
      ffha_pkg::ACT_ALLOC: predict_alloc(req, r);
      ffha_pkg::ACT_RELEASE: begin
        predict_release(rel, r.status);
        if (r.status == ffha_pkg::ST_OK)
          foreach (live_blocks[i]) if (live_blocks[i] == rel) begin
            live_blocks.delete(i);
            break;
          end
      end
      default: ;
    endcase
    r.free_bytes = free_sum;
    pending_results.push_back(r);
    items_sent++;
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("Mismatch in %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      heap_result_t want;
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", out_tdata[31:0], 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] != want.addr)
          report_mismatch("block_address", out_tdata[31:0], want.addr);
        if (out_tdata[34:32] != want.status)
          report_mismatch("status", {29'd0, out_tdata[34:32]}, {29'd0, want.status});
        if (out_tdata[66:35] != want.free_bytes)
          report_mismatch("free_bytes", out_tdata[66:35], want.free_bytes);
        if (out_tdata[71:67] != '0)
          report_mismatch("padding", {27'd0, out_tdata[71:67]}, 32'd0);
      end
    end
  end

  always @(posedge clk) begin
    if (rx_stall_on && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    out_tready <= 1'b1;
  end

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ffha_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [31:0] val);
    cfg_addr <= idx;
    cfg_wdata <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ffha_pkg::CFG_HEAP_BASE) base_reg = val;
    else size_reg = val;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [31:0] b, input logic [31:0] s);
    drain();
    write_reg(ffha_pkg::CFG_HEAP_BASE, b);
    write_reg(ffha_pkg::CFG_HEAP_SIZE, s);
    send_item(ffha_pkg::ACT_INIT, $urandom, $urandom);
  endtask

  task automatic test_reset_heap();
    send_item(ffha_pkg::ACT_ALLOC, 32'd16, 32'd0);
    send_item(ffha_pkg::ACT_RELEASE, 32'd0, 32'd0);
    send_item(ffha_pkg::ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_directed();
    reconfigure(32'hFFFF_FFF0, 32'd256);
    send_item(ffha_pkg::ACT_ALLOC, 32'd0, 32'd0);
    send_item(ffha_pkg::ACT_ALLOC, 32'd512, 32'd0);
    send_item(ffha_pkg::ACT_ALLOC, 32'd32, 32'd0);
    send_item(ffha_pkg::ACT_RELEASE, 32'd0, 32'h1234);
    send_item(ffha_pkg::ACT_RELEASE, 32'd0, 32'h0000_0010);
    send_item(ffha_pkg::ACT_ALLOC, 32'd224, 32'd0);
    send_item(ffha_pkg::ACT_ALLOC, 32'd1, 32'd0);
    for (int i = 0; i < 17; i++) send_item(ffha_pkg::ACT_ALLOC, 32'd1, 32'd0);
    reconfigure(32'd0, 32'd0);
    send_item(ffha_pkg::ACT_ALLOC, 32'd1, 32'd0);
    reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ffha_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_item(ffha_pkg::ACT_RELEASE, 32'd0, 32'hFFFF_FFFF);
    send_item(ffha_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 32'd0);
  endtask

  task automatic test_random(input int count);
    logic [31:0] sz, addr;
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i % 80 == 0) reconfigure($urandom, $urandom_range(1, 4096));
      if (i == 200) drain();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        sz = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 600);
        send_item(ffha_pkg::ACT_ALLOC, sz, $urandom);
      end else if (pick < 85 && live_blocks.size() != 0) begin
        addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        send_item(ffha_pkg::ACT_RELEASE, $urandom, addr);
      end else if (pick < 95) begin
        send_item(ffha_pkg::ACT_RELEASE, $urandom, $urandom);
      end else begin
        send_item(pick[0] ? ffha_pkg::ACT_INIT : ffha_pkg::ACT_UNUSED, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    base_reg = ffha_pkg::HEAP_BASE_RST;
    size_reg = ffha_pkg::HEAP_SIZE_RST;
    heap_init_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_heap();
    test_directed();
    test_random(330);
    tx_gap_on = 1'b0;
    rx_stall_on = 1'b0;
    test_random(60);
    drain();
    $display("Sent %0d items and checked %0d results over several heap settings,",
             items_sent, results_seen);
    $display("including zero-size, no-fit, pool-exhaustion and unknown-address cases.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
